FILE: hdl/csvf_pkg.sv
// Shared widths, constants, types and fixed-point helpers of the SVF cascade.
package csvf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int STATE_W  = 32;
   localparam int K_W      = 25;
   localparam int U_W      = 40;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 26;
   localparam int PROD_W   = 59;
   localparam int RND_W    = PROD_W - 20;
   localparam int ACC_W    = 64;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [K_W-1:0]    TWO_THIRDS_Q20 = 25'd699051;
   localparam logic [COEF_W-1:0] COEF_G_RST     = 24'd1048576;
   localparam logic [COEF_W-1:0] COEF_H_RST     = 24'd3145728;

   localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [ACC_W-1:0] HALF_Q23 = 64'sh0000_0000_0040_0000;
   localparam logic signed [PROD_W-1:0] HALF_Q20 = 59'sh0_0000_0000_0008_0000;

   typedef enum logic {
      REG_COEF_G = 1'b0,
      REG_COEF_H = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic                      en;
      logic signed [STATE_W-1:0] one;
      logic signed [STATE_W-1:0] two;
   } integ_wr_type;

   // Round half up, then drop 20 fraction bits.
   function automatic logic signed [RND_W-1:0] rnd20(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + HALF_Q20;
      return t[PROD_W-1:20];
   endfunction

   function automatic logic signed [ACC_W-1:0] sext_rnd(input logic signed [RND_W-1:0] v);
      return {{(ACC_W-RND_W){v[RND_W-1]}}, v};
   endfunction

   function automatic logic signed [ACC_W-1:0] sext_st(input logic signed [STATE_W-1:0] v);
      return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
   endfunction

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [STATE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[STATE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[STATE_W-1:0];
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 32'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -32'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/csvf_integ_mem.sv
// Integrator store: two state words per stage and channel, with per-entry valid bits.
module csvf_integ_mem
   import csvf_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  integ_wr_type              wr,
   input  logic [AW-1:0]             wr_addr,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [STATE_W-1:0] rd_one,
   output logic signed [STATE_W-1:0] rd_two
);

   logic [STATE_W-1:0] mem_one [DEPTH];
   logic [STATE_W-1:0] mem_two [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [STATE_W-1:0] rd_one_ff;
   logic [STATE_W-1:0] rd_two_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_one[wr_addr] <= wr.one;
         mem_two[wr_addr] <= wr.two;
      end
      if (rd_en) begin
         rd_one_ff <= mem_one[rd_addr];
         rd_two_ff <= mem_two[rd_addr];
      end
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_one = rd_vld_ff ? $signed(rd_one_ff) : '0;
   assign rd_two = rd_vld_ff ? $signed(rd_two_ff) : '0;

endmodule

FILE: hdl/cascaded_svf_antialias_lowpass.sv
// Top level: cascaded state-variable lowpass with one shared multiplier.
//
//  port group   direction  handshake                 payload
//  req_*        in         req_valid / req_stall     req_channel, req_sample_in
//  rsp_*        out        rsp_valid / rsp_stall     rsp_sample_out
//  APB          in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Each sample runs through every sequencer step of each stage in turn, paced by the
// single 33x26 multiplier, used five times per stage.
// Synchronous reset restores the coefficient defaults and clears the sequencer,
// the output register and the integrator valid bits, so all integrators read 0.
// No input while busy; the last stage holds until the output register is free.
module cascaded_svf_antialias_lowpass
   import csvf_pkg::*;
#(
   parameter int CHANNELS = 2,
   parameter int STAGES   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [PDATA_W-1:0]         pwdata,
   output logic [PDATA_W-1:0]         prdata,
   output logic                       pready
);

   localparam int DEPTH = STAGES * CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;

   // Sequencer: multiply k*s1, form u, two halves of u*h, hp, g*hp, bp, g*bp, lp.
   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_KS   = 10'b00_0000_0010,
      ST_UC   = 10'b00_0000_0100,
      ST_MH   = 10'b00_0000_1000,
      ST_ML   = 10'b00_0001_0000,
      ST_HP   = 10'b00_0010_0000,
      ST_MG   = 10'b00_0100_0000,
      ST_BP   = 10'b00_1000_0000,
      ST_MB   = 10'b01_0000_0000,
      ST_LP   = 10'b10_0000_0000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [COEF_W-1:0]         coef_g_ff, coef_g_in;
   logic [COEF_W-1:0]         coef_h_ff, coef_h_in;
   logic [K_W-1:0]            k_ff, k_in;
   logic [SW-1:0]             stage_cnt_ff, stage_cnt_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic signed [STATE_W-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0]  p_ff, p_in;
   logic signed [U_W-1:0]     u_ff, u_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [STATE_W-1:0] hp_ff, hp_in;
   logic signed [RND_W-1:0]   gh_ff, gh_in;
   logic signed [STATE_W-1:0] bp_ff, bp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       last;
   logic                       rsp_free;
   logic                       lp_go;
   logic                       csr_wr;
   logic [AW-1:0]              ch_addr;
   logic [AW-1:0]              next_addr;
   logic signed [STATE_W-1:0]  s1;
   logic signed [STATE_W-1:0]  s2;
   logic signed [RND_W-1:0]    rnd;
   logic signed [ACC_W-1:0]    hp_sum;
   logic signed [ACC_W-1:0]    hp_shift;
   logic signed [STATE_W-1:0]  lp;
   logic signed [STATE_W-1:0]  new_one;
   logic signed [STATE_W-1:0]  new_two;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   integ_wr_type               integ_wr;

   // ---------------------------------------------------------------------
   // Handshake and control
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign last      = (stage_cnt_ff == SW'(STAGES - 1));
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   // Hold the last stage until the output register can take the result.
   assign lp_go     = ~last | rsp_free;

   assign ch_addr   = (CHANNELS == 1) ? '0 : AW'(req_channel);
   assign next_addr = addr_ff + AW'(CHANNELS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      coef_g_in = coef_g_ff;
      coef_h_in = coef_h_ff;
      if (csr_wr) begin
         unique case (csr_reg_type'(paddr[2]))
            REG_COEF_G: coef_g_in = pwdata[COEF_W-1:0];
            REG_COEF_H: coef_h_in = pwdata[COEF_W-1:0];
            default:    coef_g_in = coef_g_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(paddr[2]))
         REG_COEF_G: prdata = {{(PDATA_W-COEF_W){1'b0}}, coef_g_ff};
         REG_COEF_H: prdata = {{(PDATA_W-COEF_W){1'b0}}, coef_h_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Integrator store
   // ---------------------------------------------------------------------
   // Fetch stage 0 on the input transfer, the next stage while finishing one.
   assign rd_en   = accept | ((state_ff == ST_LP) & lp_go & ~last);
   assign rd_addr = accept ? ch_addr : next_addr;

   assign integ_wr.en  = (state_ff == ST_LP) & lp_go;
   assign integ_wr.one = new_one;
   assign integ_wr.two = new_two;

   csvf_integ_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_integ (
      .clock   (clock),
      .reset   (reset),
      .wr      (integ_wr),
      .wr_addr (addr_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_one  (s1),
      .rd_two  (s2)
   );

   // ---------------------------------------------------------------------
   // Shared multiplier: operand select per sequencer step
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_KS: begin
            mul_a = {s1[STATE_W-1], s1};
            mul_b = {1'b0, k_ff};
         end
         ST_MH: begin
            // Upper part of u, signed, weight 2^24.
            mul_a = {{(MUL_A_W-16){u_ff[U_W-1]}}, u_ff[U_W-1:24]};
            mul_b = {2'b00, coef_h_ff};
         end
         ST_ML: begin
            mul_a = {{(MUL_A_W-24){1'b0}}, u_ff[23:0]};
            mul_b = {2'b00, coef_h_ff};
         end
         ST_MG: begin
            mul_a = {hp_ff[STATE_W-1], hp_ff};
            mul_b = {2'b00, coef_g_ff};
         end
         ST_MB: begin
            mul_a = {bp_ff[STATE_W-1], bp_ff};
            mul_b = {2'b00, coef_g_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign p_in = mul_a * mul_b;

   // ---------------------------------------------------------------------
   // Stage arithmetic around the product register
   // ---------------------------------------------------------------------
   assign rnd = rnd20(p_ff);

   // u = x - round(k*s1) - s2
   assign u_in = {{(U_W-STATE_W){x_ff[STATE_W-1]}}, x_ff}
               - {{(U_W-RND_W){rnd[RND_W-1]}}, rnd}
               - {{(U_W-STATE_W){s2[STATE_W-1]}}, s2};

   // Join the two partial products of u*h, round at bit 23 and saturate.
   assign acc_in   = {{(ACC_W-PROD_W){p_ff[PROD_W-1]}}, p_ff} <<< 24;
   assign hp_sum   = acc_ff + {{(ACC_W-PROD_W){p_ff[PROD_W-1]}}, p_ff} + HALF_Q23;
   assign hp_shift = hp_sum >>> 23;
   assign hp_in    = sat32(hp_shift);

   assign gh_in = rnd;
   assign bp_in = sat32(sext_rnd(rnd) + sext_st(s1));

   assign lp      = sat32(sext_rnd(rnd) + sext_st(s2));
   assign new_one = sat32(sext_rnd(gh_ff) + sext_st(bp_ff));
   assign new_two = sat32(sext_rnd(rnd) + sext_st(lp));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      stage_cnt_in = stage_cnt_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_KS;
               stage_cnt_in = '0;
               addr_in      = ch_addr;
               x_in     = {{(STATE_W-SAMPLE_W){req_sample_in[SAMPLE_W-1]}}, req_sample_in};
               k_in     = TWO_THIRDS_Q20 + {1'b0, coef_g_ff};
            end
         end
         ST_KS: state_in = ST_UC;
         ST_UC: state_in = ST_MH;
         ST_MH: state_in = ST_ML;
         ST_ML: state_in = ST_HP;
         ST_HP: state_in = ST_MG;
         ST_MG: state_in = ST_BP;
         ST_BP: state_in = ST_MB;
         ST_MB: state_in = ST_LP;
         ST_LP: begin
            if (lp_go) begin
               x_in = lp;
               if (last) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = sat24(lp);
               end else begin
                  state_in     = ST_KS;
                  stage_cnt_in = stage_cnt_ff + SW'(1);
                  addr_in      = next_addr;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coef_g_ff    <= COEF_G_RST;
         coef_h_ff    <= COEF_H_RST;
         rsp_valid_ff <= 1'b0;
         stage_cnt_ff <= '0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         coef_g_ff    <= coef_g_in;
         coef_h_ff    <= coef_h_in;
         rsp_valid_ff <= rsp_valid_in;
         stage_cnt_ff <= stage_cnt_in;
         addr_ff      <= addr_in;
      end
   end

   // Datapath registers, loaded only in their own step. The product holds
   // while the last stage waits for the output register.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff inside {ST_KS, ST_MH, ST_ML, ST_MG, ST_MB}) begin
         p_ff <= p_in;
      end
      if (state_ff == ST_UC) begin
         u_ff <= u_in;
      end
      if (state_ff == ST_ML) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_HP) begin
         hp_ff <= hp_in;
      end
      if (state_ff == ST_BP) begin
         gh_ff <= gh_in;
         bp_ff <= bp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LP && lp_go && last) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("last stage finished without presenting a result");

   a_hold_lp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LP && !lp_go) |=> (state_ff == ST_LP && $stable(rsp_data_ff)))
      else $error("last stage left while output register was occupied");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ({1'b0, addr_ff} < (AW + 1)'(DEPTH)))
      else $error("integrator address out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LP))
      else $error("result raised outside the final stage");

endmodule

FILE: test/cascaded_svf_antialias_lowpass_test.sv
// Self-checking testbench of the four-stage state-variable lowpass cascade.
`timescale 1ns / 1ps

module cascaded_svf_antialias_lowpass_test
   import csvf_pkg::*;
();

   localparam int NCH = 2;
   localparam int NST = 4;
   // Sequencer occupancy of one sample, idle step included.
   localparam int ITEM_CYCLES = 9 * NST + 1;
   localparam int DRAIN_CYCLES = ITEM_CYCLES + 3;
   localparam int HOLD_CYCLES = 500;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 116;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // A directed row is either a sample transfer or a register write. Where the
   // output can be read off directly, known is set and want holds it.
   typedef struct packed {
      row_kind_type               kind;
      csr_reg_type                regsel;
      logic [23:0]                value;
      logic                       ch;
      logic                       known;
      logic signed [SAMPLE_W-1:0] want;
   } step_row_type;

   localparam int ROWS = 28;

   step_row_type directed_rows [0:ROWS-1] = '{
      // straight after reset: silence in gives silence out on both channels
      '{ROW_SAMPLE, REG_COEF_G, 24'h000000, 1'b0, 1'b1, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h000000, 1'b1, 1'b1, 24'sh000000},
      // zero tuning gain: integrators never move, so output stays at zero
      '{ROW_WRITE,  REG_COEF_G, 24'h000000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b1, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b1, 1'b1, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h000001, 1'b0, 1'b1, 24'sh000000},
      // unity gain, full-scale steps on both channels
      '{ROW_WRITE,  REG_COEF_G, 24'h100000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b1, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'hFFFFFF, 1'b1, 1'b0, 24'sh000000},
      // normaliser far above 1.0 is used as written
      '{ROW_WRITE,  REG_COEF_H, 24'hFFFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b1, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b1, 1'b0, 24'sh000000},
      // largest gain drives the integrators into saturation
      '{ROW_WRITE,  REG_COEF_G, 24'hFFFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h800000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b1, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h555555, 1'b1, 1'b0, 24'sh000000},
      // zero normaliser: highpass is zero, so the first integrators hold their state
      '{ROW_WRITE,  REG_COEF_H, 24'h000000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'hAAAAAA, 1'b0, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h000001, 1'b1, 1'b0, 24'sh000000},
      '{ROW_SAMPLE, REG_COEF_G, 24'h7FFFFF, 1'b0, 1'b0, 24'sh000000},
      '{ROW_WRITE,  REG_COEF_G, 24'h100000, 1'b0, 1'b0, 24'sh000000},
      '{ROW_WRITE,  REG_COEF_H, 24'h300000, 1'b0, 1'b0, 24'sh000000}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_channel;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [PADDR_W-1:0]         paddr;
   logic [PDATA_W-1:0]         pwdata;
   logic [PDATA_W-1:0]         prdata;
   logic                       pready;

   // Predictor copy of the coefficients and of every integrator.
   logic [COEF_W-1:0] tune_g;
   logic [COEF_W-1:0] norm_h;
   int                first_integ [NST*NCH];
   int                second_integ [NST*NCH];

   logic signed [SAMPLE_W-1:0] out_expected [$];
   int  errors;
   bit  quiet;          // no idling on either side while set
   bit  hold_rsp_req;   // ask the receiver for one long hold-off

   cascaded_svf_antialias_lowpass #(
      .CHANNELS(NCH),
      .STAGES  (NST)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_channel   (req_channel),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_fail(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Round half up, then drop n fraction bits (>>> floors on signed values).
   function automatic longint round_off(input longint v, input int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Run one sample through all stages of its channel, advance the
   // integrators, and return the saturated lowpass output.
   function automatic logic signed [SAMPLE_W-1:0] cascade_step(
      input logic ch, input logic signed [SAMPLE_W-1:0] smp);
      longint x, g, h, k, s1, s2, u, hp, gh, bp, gb, lp;
      int     idx;
      int     st;
      x = longint'(smp);
      g = longint'({40'd0, tune_g});
      h = longint'({40'd0, norm_h});
      k = longint'({39'd0, TWO_THIRDS_Q20}) + g;
      for (st = 0; st < NST; st++) begin
         idx = st * NCH + int'(ch);
         s1  = longint'(first_integ[idx]);
         s2  = longint'(second_integ[idx]);
         u   = x - round_off(k * s1, 20) - s2;
         hp  = clip32(round_off(u * h, 23));
         gh  = round_off(g * hp, 20);
         bp  = clip32(gh + s1);
         gb  = round_off(g * bp, 20);
         lp  = clip32(gb + s2);
         first_integ[idx]  = int'(clip32(gh + bp));
         second_integ[idx] = int'(clip32(gb + lp));
         x = lp;
      end
      if (x > 64'sd8388607) begin
         x = 64'sd8388607;
      end else if (x < -64'sd8388608) begin
         x = -64'sd8388608;
      end
      return x[SAMPLE_W-1:0];
   endfunction

   // Normaliser 1/(1+2g/3+g*g) in Q0.23 for a Q4.20 gain.
   function automatic logic [COEF_W-1:0] norm_for(input logic [COEF_W-1:0] g);
      real gr;
      gr = real'(g) / 1048576.0;
      return COEF_W'($rtoi(8388608.0 / (1.0 + 2.0 * gr / 3.0 + gr * gr)));
   endfunction

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input logic signed [SAMPLE_W-1:0] last);
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9)) inside
         [0:3]:   s = SAMPLE_W'($urandom);
         [4:5]:   s = SAMPLE_W'($urandom_range(0, 8191)) - 24'sd4096;
         6:       s = 24'sh7FFFFF;
         7:       s = 24'sh800000;
         default: s = last;   // hold the level to build up a step response
      endcase
      return s;
   endfunction

   // Offer one sample after a random gap; predict its output at the transfer.
   // Valid stays high on return so a zero gap runs back to back.
   task automatic send_item(input logic ch, input logic signed [SAMPLE_W-1:0] smp,
                            input bit known, input logic signed [SAMPLE_W-1:0] want);
      int gap;
      logic signed [SAMPLE_W-1:0] predicted;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_channel   <= ch;
      req_sample_in <= smp;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = cascade_step(ch, smp);
      out_expected.push_back(known ? want : predicted);
   endtask

   // Drop valid and wait until every pending output has been taken, then let
   // the sequencer settle before anything touches the registers.
   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (out_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register, junk in the unused upper byte, then read it back.
   task automatic write_reg(input csr_reg_type r, input logic [COEF_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= {8'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (r == REG_COEF_G) begin
         tune_g = value;
      end else begin
         norm_h = value;
      end
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[COEF_W-1:0] !== value) begin
         report_fail($sformatf("%s readback %h want %h", r.name(), prdata[COEF_W-1:0], value));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: stall a random number of cycles before each output, or hold
   // off for a long stretch once when asked, then take one transfer.
   initial begin
      int n;
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = idle_draw();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compare each output transfer with the oldest prediction.
   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (out_expected.size() == 0) begin
            report_fail($sformatf("output %0d with nothing pending", rsp_sample_out));
         end else begin
            want = out_expected.pop_front();
            if (rsp_sample_out !== want) begin
               report_fail($sformatf("sample_out %0d want %0d", rsp_sample_out, want));
            end
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long.
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) || psel === 1'b1) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("cascaded_svf_antialias_lowpass_test NOT OK");
      $finish;
   end

   // Stimulus: directed rows, then random phases with fresh coefficients.
   initial begin
      logic signed [SAMPLE_W-1:0] last;
      logic [COEF_W-1:0]          g;
      logic [COEF_W-1:0]          h;
      int                         ph;
      int                         i;
      errors       = 0;
      quiet        = 1'b0;
      hold_rsp_req = 1'b0;
      tune_g       = COEF_G_RST;
      norm_h       = COEF_H_RST;
      for (i = 0; i < NST * NCH; i++) begin
         first_integ[i]  = 0;
         second_integ[i] = 0;
      end
      last          = '0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_channel   <= 1'b0;
      req_sample_in <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_outputs();
            write_reg(directed_rows[i].regsel, directed_rows[i].value);
         end else begin
            send_item(directed_rows[i].ch, directed_rows[i].value,
                      directed_rows[i].known, directed_rows[i].want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         drain_outputs();
         case (ph)
            0: begin g = COEF_W'($urandom_range(1 << 16, 1 << 21)); h = norm_for(g); end
            1: begin g = 24'hFFFFFF;                                 h = norm_for(g); end
            2: begin g = COEF_W'($urandom_range(0, 1 << 22));        h = norm_for(g); end
            3: begin g = COEF_W'($urandom_range(1, 255));            h = 24'h800000;  end
            4: begin g = COEF_W'($urandom);                          h = COEF_W'($urandom); end
            5: begin g = 24'h100000;                                 h = 24'hFFFFFF;  end
            6: begin
               g = COEF_W'($urandom_range(0, 1 << 20));
               h = COEF_W'($urandom_range(0, 8388608));
            end
            default: begin g = COEF_G_RST; h = COEF_H_RST; end
         endcase
         write_reg(REG_COEF_G, g);
         write_reg(REG_COEF_H, h);
         quiet = (ph % 3 == 1);
         // hold the output side long enough that the block backs up its input
         if (ph == 2) hold_rsp_req = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // pause the sender until every pending output is out
            if (ph == 4 && i == PHASE_ITEMS / 2) drain_outputs();
            last = pick_sample(last);
            send_item(1'($urandom_range(0, 1)), last, 1'b0, '0);
         end
      end

      drain_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("cascaded_svf_antialias_lowpass_test OK");
      end else begin
         $display("cascaded_svf_antialias_lowpass_test NOT OK");
      end
      $finish;
   end

endmodule
